/* src/keyed_ttl_table_with_oldest_eviction_unit_defines.svh */
// assertion helpers for the table unit
`ifndef KEYED_TTL_TABLE_WITH_OLDEST_EVICTION_UNIT_DEFINES_SVH
`define KEYED_TTL_TABLE_WITH_OLDEST_EVICTION_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KTTL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define KTTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/kttl_pkg.sv */
package kttl_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam logic [31:0] MIN_HOLD_MS = 32'd30000;

  // actions
  localparam logic [1:0] ACT_SUBMIT = 2'd0;
  localparam logic [1:0] ACT_SWEEP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_REJECTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_SWEPT    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // register indexes
  localparam logic [1:0] REG_CAPACITY    = 2'd0;
  localparam logic [1:0] REG_LIFETIME    = 2'd1;
  localparam logic [1:0] REG_SWEEP_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        entity_key;
    logic [31:0]        now_ms;
    logic               geometry_ok;
    logic               has_expiry;
    logic signed [31:0] remaining_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] entry_index;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] capacity;
    logic [31:0]      lifetime_ms;
    logic [CNT_W-1:0] sweep_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] last_seen_ms;
    logic [31:0] expiry_ms;
    logic        has_expiry;
  } entry_t;

  // expiry time with minimum hold, saturated
  function automatic logic [31:0] expiry_of(logic [31:0] now, logic signed [31:0] rem);
    logic [31:0] hold;
    logic [32:0] sum;
    hold = (rem < $signed(MIN_HOLD_MS)) ? MIN_HOLD_MS : rem;
    sum  = {1'b0, now} + {1'b0, hold};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic is_expired(entry_t e, logic [31:0] now, logic [31:0] life);
    logic [31:0] age;
    age = now - e.last_seen_ms;
    if (e.has_expiry) return now > e.expiry_ms;
    return (now > e.last_seen_ms) && (age > life);
  endfunction

endpackage

/* src/kttl_ram.sv */
module kttl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/kttl_ctrl.sv */
module kttl_ctrl import kttl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_t                 request,
  input  cfg_t                cfg,
  output logic                done,
  output out_t                result,
  output logic                ram_we,
  output logic [IDX_W-1:0]    ram_waddr,
  output entry_t              ram_wdata,
  output logic [IDX_W-1:0]    ram_raddr,
  input  entry_t              ram_rdata
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_KEY_RD  = 4'd1;
  localparam logic [3:0] S_KEY_CMP = 4'd2;
  localparam logic [3:0] S_EV_CHK  = 4'd3;
  localparam logic [3:0] S_OLD_RD  = 4'd4;
  localparam logic [3:0] S_OLD_CMP = 4'd5;
  localparam logic [3:0] S_DROP_RD = 4'd6;
  localparam logic [3:0] S_DROP_WR = 4'd7;
  localparam logic [3:0] S_SW_CHK  = 4'd8;
  localparam logic [3:0] S_SW_RD   = 4'd9;
  localparam logic [3:0] S_SW_TST  = 4'd10;

  logic [3:0]       state;
  in_t              req;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] removed;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] drop_slot;
  logic [31:0]      min_seen;

  logic [CNT_W-1:0] evict_limit;
  logic [IDX_W-1:0] last_slot;
  logic             idx_is_last;
  logic             key_hit;
  logic             take_oldest;
  logic [IDX_W-1:0] oldest_pick;
  logic             evict_more;
  entry_t           new_entry;

  assign busy        = (state != S_IDLE);
  assign evict_limit = ((cfg.capacity >> 3) == '0) ? CNT_W'(1) : (cfg.capacity >> 3);
  assign last_slot   = IDX_W'(count - CNT_W'(1));
  assign idx_is_last = (({1'b0, idx} + CNT_W'(1)) == count);
  assign key_hit     = (ram_rdata.key == req.entity_key);
  assign take_oldest = (idx == '0) || (ram_rdata.last_seen_ms < min_seen);
  assign oldest_pick = take_oldest ? idx : oldest;
  assign evict_more  = (count >= cfg.capacity) && (count != '0) && (removed < evict_limit);

  // entry built from the pending submit
  always_comb begin
    new_entry.key          = req.entity_key;
    new_entry.last_seen_ms = req.now_ms;
    new_entry.expiry_ms    = req.has_expiry ? expiry_of(req.now_ms, req.remaining_ms) : '0;
    new_entry.has_expiry   = req.has_expiry;
  end

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = new_entry;
    ram_raddr = idx;
    unique case (state)
      S_KEY_CMP: begin
        ram_we = key_hit;
      end
      S_EV_CHK: begin
        ram_waddr = count[IDX_W-1:0];
        ram_we    = !evict_more && (count != CNT_W'(MAX_ENTRIES));
      end
      S_DROP_RD: begin
        ram_raddr = last_slot;
      end
      S_DROP_WR: begin
        ram_waddr = drop_slot;
        ram_wdata = ram_rdata;
        ram_we    = (drop_slot != last_slot);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req     <= request;
            idx     <= '0;
            removed <= '0;
            priority if (request.action == ACT_SUBMIT && request.geometry_ok) begin
              state <= (count == '0) ? S_EV_CHK : S_KEY_RD;
            end else if (request.action == ACT_SWEEP) begin
              state <= S_SW_CHK;
            end else if (request.action == ACT_CLEAR) begin
              count  <= '0;
              done   <= 1'b1;
              result <= '{ST_CLEARED, '0, count, '0};
            end else begin
              done   <= 1'b1;
              result <= '{ST_REJECTED, '0, '0, count};
            end
          end
        end
        // key match scan
        S_KEY_RD: begin
          state <= S_KEY_CMP;
        end
        S_KEY_CMP: begin
          priority if (key_hit) begin
            done   <= 1'b1;
            result <= '{ST_UPDATED, idx, '0, count};
            state  <= S_IDLE;
          end else if (idx_is_last) begin
            state <= S_EV_CHK;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_KEY_RD;
          end
        end
        // evict or insert
        S_EV_CHK: begin
          priority if (evict_more) begin
            idx   <= '0;
            state <= S_OLD_RD;
          end else if (count == CNT_W'(MAX_ENTRIES)) begin
            done   <= 1'b1;
            result <= '{ST_FULL, '0, removed, count};
            state  <= S_IDLE;
          end else begin
            count  <= count + CNT_W'(1);
            done   <= 1'b1;
            result <= '{ST_INSERTED, count[IDX_W-1:0], removed, count + CNT_W'(1)};
            state  <= S_IDLE;
          end
        end
        // oldest entry scan
        S_OLD_RD: begin
          state <= S_OLD_CMP;
        end
        S_OLD_CMP: begin
          if (take_oldest) begin
            min_seen <= ram_rdata.last_seen_ms;
          end
          oldest <= oldest_pick;
          if (idx_is_last) begin
            drop_slot <= oldest_pick;
            state     <= S_DROP_RD;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_OLD_RD;
          end
        end
        // move last entry into the freed slot
        S_DROP_RD: begin
          state <= S_DROP_WR;
        end
        S_DROP_WR: begin
          count   <= count - CNT_W'(1);
          removed <= removed + CNT_W'(1);
          state   <= (req.action == ACT_SWEEP) ? S_SW_CHK : S_EV_CHK;
        end
        // expiry sweep
        S_SW_CHK: begin
          if (({1'b0, idx} < count) && (removed < cfg.sweep_limit)) begin
            state <= S_SW_RD;
          end else begin
            done   <= 1'b1;
            result <= '{ST_SWEPT, '0, removed, count};
            state  <= S_IDLE;
          end
        end
        S_SW_RD: begin
          state <= S_SW_TST;
        end
        S_SW_TST: begin
          priority if (is_expired(ram_rdata, req.now_ms, cfg.lifetime_ms)) begin
            drop_slot <= idx;
            state     <= S_DROP_RD;
          end else if (idx_is_last) begin
            // last entry kept, the index cannot step past the table end
            done   <= 1'b1;
            result <= '{ST_SWEPT, '0, removed, count};
            state  <= S_IDLE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SW_CHK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/keyed_ttl_table_with_oldest_eviction_unit.sv */
// Keyed table of entries with lifetime expiry and oldest-entry eviction.
// A request is taken when start is high and busy is low; request.action selects
// submit, expiry sweep or clear. Configuration is written through wr_en, wr_index
// and wr_data (index 0 capacity, 1 lifetime_ms, 2 sweep_limit); the user must
// write it only while the unit is idle, as the unit itself does not enforce this.
// Each request gives exactly one result: done is high for one cycle with result
// valid; the receiver cannot stall and must take it then. busy is low in that cycle.
// A new request is not taken until the last one has given its result. Each entry
// visit is a read and then a compare through the single registered read port of
// the entry memory. Clear and reject give their result in the next cycle; a
// submit scans the held keys and updates a match; otherwise, for each evicted
// entry, it scans all entries for the oldest and moves the last entry into the
// freed slot, then inserts. A sweep tests each entry and frees each expired one.
// Reset empties the table and loads capacity 256, lifetime 120000, sweep limit 32;
// the memory contents are not cleared and need no clearing pass.
module keyed_ttl_table_with_oldest_eviction_unit import kttl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         request,
  output logic        done,
  output out_t        result,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data
);

`include "keyed_ttl_table_with_oldest_eviction_unit_defines.svh"

  cfg_t             cfg;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rbits;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity    <= CNT_W'(256);
      cfg.lifetime_ms <= 32'd120000;
      cfg.sweep_limit <= CNT_W'(32);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CAPACITY:    cfg.capacity    <= wr_data[CNT_W-1:0];
        REG_LIFETIME:    cfg.lifetime_ms <= wr_data;
        REG_SWEEP_LIMIT: cfg.sweep_limit <= wr_data[CNT_W-1:0];
        default:         cfg.capacity    <= cfg.capacity;
      endcase
    end
  end

  kttl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cfg       (cfg),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  // entry memory
  kttl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  `KTTL_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
  `KTTL_ASSERT_SAME(a_insert_last, done && result.status == ST_INSERTED, result.entry_index == IDX_W'(result.occupancy - CNT_W'(1)), "insert not at table end")
  `KTTL_ASSERT_NEXT(a_clear_fast, start && !busy && request.action == ACT_CLEAR, done && result.occupancy == '0, "clear did not empty the table")

endmodule

/* test/kttl_checker.sv */
module kttl_checker import kttl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  in_t         request,
  input  logic        done,
  input  out_t        result,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the table and its registers
  logic [CNT_W-1:0] cap_q;
  logic [31:0]      life_q;
  logic [CNT_W-1:0] sweep_lim_q;
  logic [31:0]      keys    [MAX_ENTRIES];
  logic [31:0]      seen    [MAX_ENTRIES];
  logic [31:0]      expiry  [MAX_ENTRIES];
  logic             has_exp [MAX_ENTRIES];
  int unsigned      held;
  out_t             expected_results[$];

  function automatic logic [31:0] hold_until(logic [31:0] now, logic signed [31:0] rem);
    logic [32:0] sum;
    logic [31:0] hold;
    hold = (rem < 32'sd30000) ? 32'd30000 : rem;
    sum  = {1'b0, now} + {1'b0, hold};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic aged_out(int unsigned s, logic [31:0] now);
    if (has_exp[s]) return now > expiry[s];
    return (now > seen[s]) && ((now - seen[s]) > life_q);
  endfunction

  // swap the last entry into the freed slot
  function automatic void remove_slot(int unsigned s);
    if (s >= held || held == 0) return;
    if (s != held - 1) begin
      keys[s]    = keys[held-1];
      seen[s]    = seen[held-1];
      expiry[s]  = expiry[held-1];
      has_exp[s] = has_exp[held-1];
    end
    held = held - 1;
  endfunction

  function automatic void store_slot(int unsigned s, in_t r);
    keys[s]    = r.entity_key;
    seen[s]    = r.now_ms;
    expiry[s]  = r.has_expiry ? hold_until(r.now_ms, r.remaining_ms) : 32'd0;
    has_exp[s] = r.has_expiry;
  endfunction

  function automatic out_t table_outcome(in_t r);
    out_t        o;
    int unsigned s, removed, lim, oldest;
    logic        found;
    o = '0;
    s = 0;
    removed = 0;
    found = 1'b0;
    if (r.action == ACT_SUBMIT && r.geometry_ok) begin
      for (int unsigned i = 0; i < held; i++) begin
        if (!found && keys[i] == r.entity_key) begin
          found = 1'b1;
          s = i;
        end
      end
      if (found) begin
        store_slot(s, r);
        o.status = ST_UPDATED;
      end else begin
        lim = (cap_q / 8 < 1) ? 1 : cap_q / 8;
        while (held >= cap_q && held > 0 && removed < lim) begin
          oldest = 0;
          for (int unsigned i = 1; i < held; i++)
            if (seen[i] < seen[oldest]) oldest = i;
          remove_slot(oldest);
          removed++;
        end
        if (held >= MAX_ENTRIES) begin
          o.status = ST_FULL;
        end else begin
          s = held;
          store_slot(s, r);
          held++;
          o.status = ST_INSERTED;
        end
      end
    end else if (r.action == ACT_SWEEP) begin
      s = 0;
      while (s < held && removed < sweep_lim_q) begin
        if (aged_out(s, r.now_ms)) begin
          remove_slot(s);
          removed++;
        end else begin
          s++;
        end
      end
      s = 0;
      o.status = ST_SWEPT;
    end else if (r.action == ACT_CLEAR) begin
      removed = held;
      held = 0;
      o.status = ST_CLEARED;
    end else begin
      o.status = ST_REJECTED;
    end
    o.entry_index   = s[IDX_W-1:0];
    o.removed_count = removed[CNT_W-1:0];
    o.occupancy     = held[CNT_W-1:0];
    return o;
  endfunction

  // watch register writes, requests and results
  always @(posedge clk) begin
    out_t exp_r;
    if (rst) begin
      cap_q = 9'd256;
      life_q = 32'd120000;
      sweep_lim_q = 9'd32;
      held = 0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_CAPACITY:    cap_q = wr_data[CNT_W-1:0];
          REG_LIFETIME:    life_q = wr_data;
          REG_SWEEP_LIMIT: sweep_lim_q = wr_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d", result.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, result.status);
            errors++;
          end
          if (result.entry_index !== exp_r.entry_index) begin
            $error("entry_index expected %0d actual %0d", exp_r.entry_index,
                   result.entry_index);
            errors++;
          end
          if (result.removed_count !== exp_r.removed_count) begin
            $error("removed_count expected %0d actual %0d", exp_r.removed_count,
                   result.removed_count);
            errors++;
          end
          if (result.occupancy !== exp_r.occupancy) begin
            $error("occupancy expected %0d actual %0d", exp_r.occupancy, result.occupancy);
            errors++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(table_outcome(request));
    end
    pending = expected_results.size();
  end

endmodule

/* test/tb_keyed_ttl_table_with_oldest_eviction_unit.sv */
module tb_keyed_ttl_table_with_oldest_eviction_unit;
  import kttl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint CYCLE_LIMIT = 20_000_000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_t         request;
  logic        done;
  out_t        result;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;
  int          errors;
  int          pending;
  longint      cycles;
  int          quiet_left;
  logic [31:0] clock_ms;
  logic [31:0] key_base;

  keyed_ttl_table_with_oldest_eviction_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  kttl_checker table_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("keyed_ttl_table_with_oldest_eviction_unit verification failed");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones, and quiet stretches with none
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) quiet_left = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send(input in_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] cap, input logic [31:0] life,
                           input logic [31:0] lim);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_LIFETIME, life);
    write_reg(REG_SWEEP_LIMIT, lim);
  endtask

  function automatic in_t item(logic [1:0] act, logic [31:0] key, logic [31:0] now,
                               logic geo, logic hx, logic [31:0] rem);
    in_t r;
    r.action = act;
    r.entity_key = key;
    r.now_ms = now;
    r.geometry_ok = geo;
    r.has_expiry = hx;
    r.remaining_ms = rem;
    return r;
  endfunction

  // random request drawn from a key pool, time mostly moving forward
  function automatic in_t random_request(int pool);
    in_t r;
    int  pick;
    pick = $urandom_range(0, 99);
    r.action = (pick < 82) ? ACT_SUBMIT : (pick < 94) ? ACT_SWEEP :
               (pick < 97) ? ACT_CLEAR : ACT_UNUSED;
    r.entity_key = ($urandom_range(0, 9) == 0) ? $urandom
                 : key_base + $urandom_range(0, pool - 1);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 3000);
    r.now_ms = clock_ms;
    r.geometry_ok = ($urandom_range(0, 19) != 0);
    r.has_expiry = $urandom_range(0, 1);
    r.remaining_ms = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 60000) - 20000;
    return r;
  endfunction

  task automatic random_phase(int count, int pool);
    key_base = $urandom;
    for (int i = 0; i < count; i++) begin
      send(random_request(pool));
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    wr_en = 1'b0;
    wr_index = REG_CAPACITY;
    wr_data = '0;
    quiet_left = 0;
    clock_ms = 32'd1000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests on reset settings
    send(item(ACT_SUBMIT, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0));
    send(item(ACT_SUBMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF));
    send(item(ACT_SUBMIT, 32'h1234_5678, 32'd5000, 1'b1, 1'b1, 32'h8000_0000));
    send(item(ACT_SUBMIT, 32'hAAAA_5555, 32'd6000, 1'b0, 1'b1, 32'd1));
    send(item(ACT_UNUSED, 32'h5555_AAAA, 32'd6000, 1'b1, 1'b0, 32'd0));
    send(item(ACT_SUBMIT, 32'h0, 32'd7000, 1'b1, 1'b1, 32'd100000));
    send(item(ACT_SUBMIT, 32'h1234_5678, 32'd8000, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send(item(ACT_SWEEP, 32'h0, 32'd10, 1'b1, 1'b0, 32'd0));
    send(item(ACT_SWEEP, 32'h0, 32'd107_001, 1'b1, 1'b0, 32'd0));
    send(item(ACT_SWEEP, 32'h0, 32'd200_000, 1'b1, 1'b0, 32'd0));
    send(item(ACT_SUBMIT, 32'h7, 32'd300_000, 1'b1, 1'b0, 32'd0));
    send(item(ACT_CLEAR, 32'h0, 32'd300_000, 1'b1, 1'b0, 32'd0));
    send(item(ACT_CLEAR, 32'h0, 32'd300_000, 1'b1, 1'b0, 32'd0));

    // small tables under several settings
    configure(32'd4, 32'd0, 32'd1);
    random_phase(220, 8);
    configure(32'd0, 32'd1000, 32'd0);
    random_phase(200, 4);
    configure(32'd16, 32'd50000, 32'd3);
    random_phase(230, 24);
    configure(32'd1, 32'hFFFF_FFFF, 32'd511);
    random_phase(200, 3);

    // fill past the table size with capacity above it
    configure(32'd300, 32'd120000, 32'd256);
    send(item(ACT_CLEAR, 32'h0, clock_ms, 1'b1, 1'b0, 32'd0));
    key_base = $urandom;
    for (int i = 0; i < 258; i++)
      send(item(ACT_SUBMIT, key_base + i, clock_ms + i, 1'b1, i[0], $urandom));
    send(item(ACT_SUBMIT, key_base + 3, clock_ms + 500, 1'b1, 1'b0, 32'd0));

    // full table at a capacity equal to the table size evicts in bulk
    configure(32'd256, 32'd2000, 32'd32);
    for (int i = 0; i < 4; i++)
      send(item(ACT_SUBMIT, $urandom, clock_ms + 600 + i, 1'b1, 1'b0, 32'd0));
    send(item(ACT_SWEEP, 32'h0, clock_ms + 3000, 1'b1, 1'b0, 32'd0));

    // capacity lowered under the occupancy
    configure(32'd8, 32'd5000, 32'd2);
    clock_ms = clock_ms + 1000;
    random_phase(230, 16);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("keyed_ttl_table_with_oldest_eviction_unit verification clean");
    end else begin
      $display("keyed_ttl_table_with_oldest_eviction_unit verification failed");
    end
    $finish;
  end

endmodule
